// File: hw/rtl/bts_pkg.sv
// Shared types, constants and helper functions for the bilinear texture sampler.
// Used by bilinear_texture_sample, bts_mac and bts_checker; depends on nothing.
package bts_pkg;

    localparam int MAX_SIDE     = 64;
    localparam int STORE_TEXELS = 4096;
    localparam int FRAC_BITS    = 8;

    localparam int COORD_W    = 14;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int SIDE_W     = 7;
    localparam int CMP_W      = (INT_W + 1 > SIDE_W) ? INT_W + 1 : SIDE_W;
    localparam int BYTE_W     = 8;
    localparam int TEXEL_W    = 32;
    localparam int ADDR_W     = 12;
    localparam int DEC_W      = 16;
    localparam int A_W        = DEC_W + FRAC_BITS;
    localparam int B_W        = (FRAC_BITS + 1 > SIDE_W) ? FRAC_BITS + 1 : SIDE_W;
    localparam int ACC_W      = DEC_W + 2 * FRAC_BITS + 1;
    localparam int IDX_W      = 2 * SIDE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DEPTH_W    = 2;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 3;
    localparam int CH_W       = 2;
    localparam int NUM_TEXELS = 4;
    localparam int NUM_CH     = 3;
    localparam int LINE_LEN   = NUM_TEXELS * NUM_CH;

    localparam logic [B_W-1:0]   WEIGHT_ONE = B_W'(1) << FRAC_BITS;
    localparam logic [ACC_W:0]   RND_HALF   = (ACC_W + 1)'(255) << (2 * FRAC_BITS - 1);
    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_GREY = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_RGB  = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_RGBA = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [SIDE_W-1:0]  SIDE_RESET  = SIDE_W'(MAX_SIDE);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_RGB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_READ,
        ST_DECODE,
        ST_BLEND
    } t_state;

    typedef struct packed {
        logic           en;
        logic           acc;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
    } t_mac_op;

    function automatic logic [SIDE_W-1:0] side_limit(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bts_mac.sv
// Shared multiply-accumulate unit of the bilinear texture sampler.
// Depends on bts_pkg for operand widths and the operation struct.
module bts_mac (
    input  logic                      i_clk,
    input  bts_pkg::t_mac_op          i_op,
    output logic [bts_pkg::ACC_W-1:0] o_acc
);

    logic [bts_pkg::ACC_W-1:0]           r_acc;
    logic [bts_pkg::A_W+bts_pkg::B_W-1:0] prod;
    logic [bts_pkg::ACC_W-1:0]           addend;

    assign prod   = i_op.a * i_op.b;
    assign addend = i_op.acc ? r_acc : '0;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= addend + prod[bts_pkg::ACC_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hw/rtl/bilinear_texture_sample.sv
// Top level of the bilinear texture sampler: sequencer, texture memory and result register.
// Depends on bts_pkg and instantiates bts_mac.
//
// Usage: an input transaction either writes one texel into the texture memory or requests a
// sample at fixed-point coordinates. Texel writes are taken one per cycle while the block is
// idle and give no result. A sample keeps the block busy through one multiply for the row base,
// four reads of the single-port texture memory, twelve decode multiplies and eighteen blend
// multiply-accumulates, every multiply going to the single shared multiply-accumulate unit.
// The result transaction is offered at the same edge at which o_in_ready returns.
// The result sits in an output register, so further writes and a new sample are accepted while
// it waits; a second sample holds in its final step until the receiver takes the first result.
// The configuration channel is always ready and must only be written while the block is idle.
// Reset returns the configuration registers to 64 x 64 RGB and drops any pending result. The
// texture memory is not cleared; texels must be written before they are sampled.
module bilinear_texture_sample #(
    parameter int STORE_TEXELS = bts_pkg::STORE_TEXELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [bts_pkg::ADDR_W-1:0]       i_texel_addr,
    input  logic [bts_pkg::BYTE_W-1:0]       i_texel_red,
    input  logic [bts_pkg::BYTE_W-1:0]       i_texel_green,
    input  logic [bts_pkg::BYTE_W-1:0]       i_texel_blue,
    input  logic [bts_pkg::BYTE_W-1:0]       i_texel_alpha,
    input  logic [bts_pkg::COORD_W-1:0]      i_coord_s,
    input  logic [bts_pkg::COORD_W-1:0]      i_coord_t,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bts_pkg::BYTE_W-1:0]       o_out_red,
    output logic [bts_pkg::BYTE_W-1:0]       o_out_green,
    output logic [bts_pkg::BYTE_W-1:0]       o_out_blue,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1;
    localparam int LW = ((bts_pkg::IDX_W > AW) ? bts_pkg::IDX_W : AW) + 1;

    localparam logic [bts_pkg::CNT_W-1:0] READ_LAST   = bts_pkg::CNT_W'(bts_pkg::NUM_TEXELS);
    localparam logic [bts_pkg::CNT_W-1:0] DECODE_LAST = bts_pkg::CNT_W'(bts_pkg::LINE_LEN);

    localparam logic [bts_pkg::STEP_W-1:0] STEP_A0    = 3'd0;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_A1    = 3'd1;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_B0    = 3'd2;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_B1    = 3'd3;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_V0    = 3'd4;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_V1    = 3'd5;
    localparam logic [bts_pkg::STEP_W-1:0] STEP_ROUND = 3'd6;

    localparam logic [bts_pkg::CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [bts_pkg::CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [bts_pkg::CH_W-1:0] CH_LAST  = 2'd2;

    bts_pkg::t_state r_state, n_state;
    logic [bts_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [bts_pkg::STEP_W-1:0] r_step, n_step;
    logic [bts_pkg::CH_W-1:0]   r_ch, n_ch;
    logic                       r_pend;
    logic                       r_out_valid;

    logic [bts_pkg::SIDE_W-1:0]  r_width, r_height;
    logic [bts_pkg::DEPTH_W-1:0] r_depth;

    logic [bts_pkg::SIDE_W-1:0]    r_w, r_c0, r_c1, r_r0, r_r1;
    logic [bts_pkg::FRAC_BITS-1:0] r_ws, r_wt;
    logic [bts_pkg::TEXEL_W-1:0]   r_texel [bts_pkg::NUM_TEXELS];
    logic                          r_rd_ok;
    logic [bts_pkg::DEC_W-1:0]     r_line [bts_pkg::LINE_LEN];
    logic [bts_pkg::A_W-1:0]       r_a, r_b;
    logic [bts_pkg::BYTE_W-1:0]    r_res_red, r_res_green;
    logic [bts_pkg::BYTE_W-1:0]    r_out_red, r_out_green, r_out_blue;

    logic [bts_pkg::TEXEL_W-1:0] mem [STORE_TEXELS];
    logic [bts_pkg::TEXEL_W-1:0] r_rd_data;

    bts_pkg::t_mac_op          mac_op;
    logic [bts_pkg::ACC_W-1:0] mac_acc;

    logic in_acc, sample_go, mem_we, wr_ok, rd_ok, finish, next_ch;
    logic [bts_pkg::SIDE_W-1:0]  w_lim, h_lim;
    logic [bts_pkg::CMP_W-1:0]   s_int, t_int, s_int1, t_int1, w_m1, h_m1;
    logic [bts_pkg::SIDE_W-1:0]  c0, c1, rw0, rw1;
    logic [bts_pkg::IDX_W-1:0]   base0, base1, rd_idx;
    logic [LW-1:0]               mem_addr;
    logic [bts_pkg::TEXEL_W-1:0] wr_word, dec_word;
    logic [bts_pkg::BYTE_W-1:0]  dec_byte, dec_mult;
    logic [1:0]                  tex_wr_idx;
    logic [bts_pkg::B_W-1:0]     ws_b, wt_b, ws_inv, wt_inv;
    logic [bts_pkg::ACC_W:0]     rnd_sum;
    logic [bts_pkg::DEC_W:0]     rnd_y;
    logic [bts_pkg::BYTE_W:0]    rnd_q0;
    logic [bts_pkg::BYTE_W+1:0]  rnd_rem, rnd_q;
    logic [bts_pkg::BYTE_W-1:0]  rnd_byte;

    bts_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_acc (mac_acc)
    );

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == bts_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

    // Coordinate split and edge clamping for a new sample.
    always_comb begin
        w_lim  = bts_pkg::side_limit(r_width);
        h_lim  = bts_pkg::side_limit(r_height);
        s_int  = bts_pkg::CMP_W'(i_coord_s[bts_pkg::COORD_W-1:bts_pkg::FRAC_BITS]);
        t_int  = bts_pkg::CMP_W'(i_coord_t[bts_pkg::COORD_W-1:bts_pkg::FRAC_BITS]);
        s_int1 = s_int + bts_pkg::CMP_W'(1);
        t_int1 = t_int + bts_pkg::CMP_W'(1);
        w_m1   = bts_pkg::CMP_W'(w_lim) - bts_pkg::CMP_W'(1);
        h_m1   = bts_pkg::CMP_W'(h_lim) - bts_pkg::CMP_W'(1);
        c0     = (s_int > w_m1) ? w_m1[bts_pkg::SIDE_W-1:0] : s_int[bts_pkg::SIDE_W-1:0];
        c1     = (s_int1 > w_m1) ? w_m1[bts_pkg::SIDE_W-1:0] : s_int1[bts_pkg::SIDE_W-1:0];
        rw0    = (t_int > h_m1) ? h_m1[bts_pkg::SIDE_W-1:0] : t_int[bts_pkg::SIDE_W-1:0];
        rw1    = (t_int1 > h_m1) ? h_m1[bts_pkg::SIDE_W-1:0] : t_int1[bts_pkg::SIDE_W-1:0];
    end

    // Texel addressing: the row base comes from the shared unit and stays there during reads.
    always_comb begin
        base0  = mac_acc[bts_pkg::IDX_W-1:0];
        base1  = base0 + ((r_r1 != r_r0) ? bts_pkg::IDX_W'(r_w) : '0);
        rd_idx = (r_cnt[1] ? base1 : base0)
               + bts_pkg::IDX_W'(r_cnt[0] ? r_c1 : r_c0);
        rd_ok  = (LW'(rd_idx) < LW'(STORE_TEXELS));
        wr_ok  = (LW'(i_texel_addr) < LW'(STORE_TEXELS));
        mem_addr = (r_state == bts_pkg::ST_IDLE) ? LW'(i_texel_addr) : LW'(rd_idx);
        wr_word  = {i_texel_alpha, i_texel_blue, i_texel_green, i_texel_red};
        tex_wr_idx = 2'(r_cnt - bts_pkg::CNT_W'(1));
    end

    // Texel decode operands: the byte and its multiplier for one texel and channel.
    always_comb begin
        dec_word = r_texel[r_cnt[1:0]];
        dec_mult = (r_depth == bts_pkg::DEPTH_RGBA) ? dec_word[31:24] : bts_pkg::BYTE_FULL;
        unique case (r_cnt[3:2])
            CH_RED:   dec_byte = dec_word[7:0];
            CH_GREEN: dec_byte = dec_word[15:8];
            default:  dec_byte = dec_word[23:16];
        endcase
        if (r_depth == bts_pkg::DEPTH_GREY) begin
            dec_byte = dec_word[7:0];
        end else if (r_depth != bts_pkg::DEPTH_RGB && r_depth != bts_pkg::DEPTH_RGBA) begin
            dec_byte = bts_pkg::BYTE_FULL;
            dec_mult = bts_pkg::BYTE_FULL;
        end
    end

    // Rounding divide by 255 * 2^(2F): shift, then divide by 255 with one correction.
    always_comb begin
        ws_b    = bts_pkg::B_W'(r_ws);
        wt_b    = bts_pkg::B_W'(r_wt);
        ws_inv  = bts_pkg::WEIGHT_ONE - ws_b;
        wt_inv  = bts_pkg::WEIGHT_ONE - wt_b;
        rnd_sum = {1'b0, mac_acc} + bts_pkg::RND_HALF;
        rnd_y   = rnd_sum[2*bts_pkg::FRAC_BITS +: bts_pkg::DEC_W+1];
        rnd_q0  = rnd_y[bts_pkg::DEC_W:bts_pkg::BYTE_W];
        rnd_rem = (bts_pkg::BYTE_W+2)'(rnd_y[bts_pkg::BYTE_W-1:0])
                + (bts_pkg::BYTE_W+2)'(rnd_q0);
        rnd_q   = (bts_pkg::BYTE_W+2)'(rnd_q0)
                + ((rnd_rem >= (bts_pkg::BYTE_W+2)'(255)) ? (bts_pkg::BYTE_W+2)'(1) : '0);
        rnd_byte = (rnd_q > (bts_pkg::BYTE_W+2)'(255)) ? bts_pkg::BYTE_FULL
                                                       : rnd_q[bts_pkg::BYTE_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_ch      = r_ch;
        mac_op    = '0;
        mem_we    = 1'b0;
        sample_go = 1'b0;
        finish    = 1'b0;
        next_ch   = 1'b0;
        unique case (r_state)
            bts_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == bts_pkg::KIND_SAMPLE) begin
                        sample_go = 1'b1;
                        n_state   = bts_pkg::ST_BASE;
                    end else begin
                        mem_we = wr_ok;
                    end
                end
            end
            bts_pkg::ST_BASE: begin
                mac_op.en = 1'b1;
                mac_op.a  = bts_pkg::A_W'(r_r0);
                mac_op.b  = bts_pkg::B_W'(r_w);
                n_cnt     = '0;
                n_state   = bts_pkg::ST_READ;
            end
            bts_pkg::ST_READ: begin
                if (r_cnt == READ_LAST) begin
                    n_cnt   = '0;
                    n_state = bts_pkg::ST_DECODE;
                end else begin
                    n_cnt = r_cnt + bts_pkg::CNT_W'(1);
                end
            end
            bts_pkg::ST_DECODE: begin
                if (r_cnt == DECODE_LAST) begin
                    n_step  = STEP_A0;
                    n_ch    = CH_RED;
                    n_state = bts_pkg::ST_BLEND;
                end else begin
                    mac_op.en = 1'b1;
                    mac_op.a  = bts_pkg::A_W'(dec_byte);
                    mac_op.b  = bts_pkg::B_W'(dec_mult);
                    n_cnt     = r_cnt + bts_pkg::CNT_W'(1);
                end
            end
            bts_pkg::ST_BLEND: begin
                mac_op.en = (r_step != STEP_ROUND);
                n_step    = r_step + bts_pkg::STEP_W'(1);
                unique case (r_step)
                    STEP_A0: begin
                        mac_op.a = bts_pkg::A_W'(r_line[0]);
                        mac_op.b = ws_inv;
                    end
                    STEP_A1: begin
                        mac_op.acc = 1'b1;
                        mac_op.a   = bts_pkg::A_W'(r_line[1]);
                        mac_op.b   = ws_b;
                    end
                    STEP_B0: begin
                        mac_op.a = bts_pkg::A_W'(r_line[2]);
                        mac_op.b = ws_inv;
                    end
                    STEP_B1: begin
                        mac_op.acc = 1'b1;
                        mac_op.a   = bts_pkg::A_W'(r_line[3]);
                        mac_op.b   = ws_b;
                    end
                    STEP_V0: begin
                        mac_op.a = r_a;
                        mac_op.b = wt_inv;
                    end
                    STEP_V1: begin
                        mac_op.acc = 1'b1;
                        mac_op.a   = r_b;
                        mac_op.b   = wt_b;
                    end
                    default: begin
                        n_step = r_step;
                        if (r_ch == CH_LAST) begin
                            if (!r_out_valid || i_out_ready) begin
                                finish  = 1'b1;
                                n_state = bts_pkg::ST_IDLE;
                            end
                        end else begin
                            next_ch = 1'b1;
                            n_ch    = r_ch + bts_pkg::CH_W'(1);
                            n_step  = STEP_A0;
                        end
                    end
                endcase
            end
            default: begin
                n_state = bts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bts_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_step      <= STEP_A0;
            r_ch        <= CH_RED;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= bts_pkg::SIDE_RESET;
            r_height    <= bts_pkg::SIDE_RESET;
            r_depth     <= bts_pkg::DEPTH_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_ch    <= n_ch;
            r_pend  <= (r_state == bts_pkg::ST_DECODE) && (r_cnt != DECODE_LAST);
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    bts_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[bts_pkg::SIDE_W-1:0];
                    bts_pkg::CFG_HEIGHT: r_height <= i_cfg_data[bts_pkg::SIDE_W-1:0];
                    bts_pkg::CFG_DEPTH:  r_depth  <= i_cfg_data[bts_pkg::DEPTH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr[AW-1:0]] <= wr_word;
        end
        r_rd_data <= mem[mem_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sample_go) begin
            r_w  <= w_lim;
            r_c0 <= c0;
            r_c1 <= c1;
            r_r0 <= rw0;
            r_r1 <= rw1;
            r_ws <= i_coord_s[bts_pkg::FRAC_BITS-1:0];
            r_wt <= i_coord_t[bts_pkg::FRAC_BITS-1:0];
        end
        r_rd_ok <= rd_ok;
        if (r_state == bts_pkg::ST_READ && r_cnt != '0) begin
            r_texel[tex_wr_idx] <= r_rd_ok ? r_rd_data : '0;
        end
        if (r_pend) begin
            for (int i = 0; i < bts_pkg::LINE_LEN - 1; i++) begin
                r_line[i] <= r_line[i+1];
            end
            r_line[bts_pkg::LINE_LEN-1] <= mac_acc[bts_pkg::DEC_W-1:0];
        end else if (next_ch) begin
            for (int i = 0; i < bts_pkg::LINE_LEN - bts_pkg::NUM_TEXELS; i++) begin
                r_line[i] <= r_line[i+bts_pkg::NUM_TEXELS];
            end
        end
        if (r_state == bts_pkg::ST_BLEND && r_step == STEP_B0) begin
            r_a <= mac_acc[bts_pkg::A_W-1:0];
        end
        if (r_state == bts_pkg::ST_BLEND && r_step == STEP_V0) begin
            r_b <= mac_acc[bts_pkg::A_W-1:0];
        end
        if (next_ch && r_ch == CH_RED) begin
            r_res_red <= rnd_byte;
        end
        if (next_ch && r_ch == CH_GREEN) begin
            r_res_green <= rnd_byte;
        end
        if (finish) begin
            r_out_red   <= r_res_red;
            r_out_green <= r_res_green;
            r_out_blue  <= rnd_byte;
        end
    end

endmodule

// File: hw/rtl/bts_checker.sv
// Port-level checker for bilinear_texture_sample and the bind that attaches it.
// Depends on bts_pkg for the transaction kind codes.
module bts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_kind,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [bts_pkg::BYTE_W-1:0] o_out_red,
    input logic [bts_pkg::BYTE_W-1:0] o_out_green,
    input logic [bts_pkg::BYTE_W-1:0] o_out_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result transaction dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue))
        else $error("Result payload changed while stalled.");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind == bts_pkg::KIND_SAMPLE |=> !o_in_ready)
        else $error("Input accepted again right after a sample transaction.");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind == bts_pkg::KIND_WRITE && !o_out_valid
            |=> !o_out_valid)
        else $error("A texel write produced a result transaction.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("A result appeared while the block was idle.");

endmodule

bind bilinear_texture_sample bts_checker u_bts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
